/* rtl/bpfe_pkg.sv */
// Shared types, constants and helper functions for the bicubic patch block.
// Used by every module under rtl; depends on nothing else.
package bpfe_pkg;

  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int VAL_BITS      = 48;
  localparam int CFG_BITS      = 31;
  localparam int COORD_BITS    = 32;
  localparam int SUM_BITS      = 60;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 31'd65536;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [3:0] QTY_LAST_DERIV = 4'd9;
  localparam logic [3:0] QTY_INTEGRAL   = 4'd10;

  localparam logic [1:0] REG_CELL_WIDTH     = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_INVERSE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_INVERSE_HEIGHT = 2'd3;

  localparam logic signed [SUM_BITS-1:0] VAL_MAX = SUM_BITS'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [SUM_BITS-1:0] VAL_MIN = -VAL_MAX - SUM_BITS'(1);

  typedef struct packed {
    logic [1:0]                    op;
    logic [3:0]                    sample_index;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic signed [COORD_BITS-1:0]  query_x;
    logic signed [COORD_BITS-1:0]  query_y;
    logic [3:0]                    quantity;
  } req_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] result_value;
    logic                       saturated;
  } rsp_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] cell_width;
    logic [CFG_BITS-1:0] cell_height;
    logic [CFG_BITS-1:0] inverse_width;
    logic [CFG_BITS-1:0] inverse_height;
  } cfg_t;

  typedef enum logic [1:0] {CMD_LOAD, CMD_BUILD, CMD_QUERY} cmd_kind_t;
  typedef enum logic [1:0] {QK_DERIV, QK_INTEGRAL, QK_NONE} qkind_t;

  typedef struct packed {
    cmd_kind_t                     kind;
    logic [3:0]                    sample_index;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic signed [COORD_BITS-1:0]  query_x;
    logic signed [COORD_BITS-1:0]  query_y;
    qkind_t                        qkind;
    logic [1:0]                    ox;
    logic [1:0]                    oy;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BACC, S_BRND, S_BSCL, S_BGET, S_MULW, S_QPX, S_QPXG,
    S_QPY, S_QPYG, S_QT1, S_QT2, S_QT3, S_QDIV, S_QNEXT, S_QFIN
  } back_state_t;

  typedef logic signed [5:0] kcoef_t;

  // Bicubic convolution matrix in quarter units
  localparam kcoef_t KMAT [16][16] = '{
    '{0,0,0,0,0,4,0,0,0,0,0,0,0,0,0,0},
    '{0,0,0,0,-2,0,2,0,0,0,0,0,0,0,0,0},
    '{0,0,0,0,4,-10,8,-2,0,0,0,0,0,0,0,0},
    '{0,0,0,0,-2,6,-6,2,0,0,0,0,0,0,0,0},
    '{0,-2,0,0,0,0,0,0,0,2,0,0,0,0,0,0},
    '{1,0,-1,0,0,0,0,0,-1,0,1,0,0,0,0,0},
    '{-2,5,-4,1,0,0,0,0,2,-5,4,-1,0,0,0,0},
    '{1,-3,3,-1,0,0,0,0,-1,3,-3,1,0,0,0,0},
    '{0,4,0,0,0,-10,0,0,0,8,0,0,0,-2,0,0},
    '{-2,0,2,0,5,0,-5,0,-4,0,4,0,1,0,-1,0},
    '{4,-10,8,-2,-10,25,-20,5,8,-20,16,-4,-2,5,-4,1},
    '{-2,6,-6,2,5,-15,15,-5,-4,12,-12,4,1,-3,3,-1},
    '{0,-2,0,0,0,6,0,0,0,-6,0,0,0,2,0,0},
    '{1,0,-1,0,-3,0,3,0,3,0,-3,0,-1,0,1,0},
    '{-2,5,-4,1,6,-15,12,-3,-6,15,-12,3,2,-5,4,-1},
    '{1,-3,3,-1,-3,9,-9,3,3,-9,9,-3,-1,3,-3,1}
  };

  function automatic logic [1:0] order_x(input logic [3:0] q);
    case (q)
      4'd1, 4'd4, 4'd8: order_x = 2'd1;
      4'd3, 4'd7:       order_x = 2'd2;
      4'd6:             order_x = 2'd3;
      default:          order_x = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] order_y(input logic [3:0] q);
    case (q)
      4'd2, 4'd4, 4'd7: order_y = 2'd1;
      4'd5, 4'd8:       order_y = 2'd2;
      4'd9:             order_y = 2'd3;
      default:          order_y = 2'd0;
    endcase
  endfunction

  // Falling factorial i!/(i-o)! for o <= i
  function automatic logic [2:0] fall(input logic [1:0] o, input logic [1:0] i);
    case (o)
      2'd0:    fall = 3'd1;
      2'd1:    fall = {1'b0, i};
      2'd2:    fall = (i == 2'd3) ? 3'd6 : 3'd2;
      default: fall = 3'd6;
    endcase
  endfunction

  function automatic logic [VAL_BITS-1:0] mag48(input logic signed [VAL_BITS-1:0] v);
    mag48 = v[VAL_BITS-1] ? VAL_BITS'(-v) : VAL_BITS'(v);
  endfunction

  // {clipped, value} of a wide sum clamped to the result range
  function automatic logic [VAL_BITS:0] clamp_val(input logic signed [SUM_BITS-1:0] v);
    if (v > VAL_MAX) begin
      clamp_val = {1'b1, VAL_BITS'(VAL_MAX)};
    end else if (v < VAL_MIN) begin
      clamp_val = {1'b1, VAL_BITS'(VAL_MIN)};
    end else begin
      clamp_val = {1'b0, VAL_BITS'(v)};
    end
  endfunction

endpackage

/* rtl/bicubic_patch_fit_and_evaluate.sv */
// Bicubic patch fit and evaluate: top level, configuration registers and assertions.
// Load stores one sample. Build forms each of the 16 coefficients from the 16 samples, rounds it
// and scales it as needed, 48 scaling multiplies in all, on the shared multiplier. Query forms the
// powers it needs, then multiplies out each term; the integral adds a divide per term.
// Items are carried out one at a time; a two-entry queue and a result register decouple the ports.
// Reset (rst, synchronous): clears queue and sequencer, coefficients to zero, registers to 1.0.
module bicubic_patch_fit_and_evaluate #(
  parameter int FRACTION_BITS = bpfe_pkg::FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bpfe_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bpfe_pkg::rsp_t                rsp,
  input  logic                          write_enable,
  input  logic [1:0]                    write_index,
  input  logic [bpfe_pkg::CFG_BITS-1:0] write_data
);

  bpfe_pkg::cfg_t cfg;
  bpfe_pkg::cmd_t cmd;
  bpfe_pkg::cmd_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width     <= bpfe_pkg::CFG_RESET;
      cfg.cell_height    <= bpfe_pkg::CFG_RESET;
      cfg.inverse_width  <= bpfe_pkg::CFG_RESET;
      cfg.inverse_height <= bpfe_pkg::CFG_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        bpfe_pkg::REG_CELL_WIDTH:    cfg.cell_width     <= write_data;
        bpfe_pkg::REG_CELL_HEIGHT:   cfg.cell_height    <= write_data;
        bpfe_pkg::REG_INVERSE_WIDTH: cfg.inverse_width  <= write_data;
        default:                     cfg.inverse_height <= write_data;
      endcase
    end
  end

  bpfe_front u_front (
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .full(full), .push(push), .cmd(cmd)
  );

  bpfe_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(cmd), .full(full),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  bpfe_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .cfg(cfg), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");

  a_pending_held: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("pending result dropped");

endmodule

/* rtl/bpfe_front.sv */
// Request intake: accepts requests, drops unknown opcodes, decodes the quantity.
// Depends on bpfe_pkg.
module bpfe_front (
  input  logic              req_valid,
  output logic              req_ready,
  input  bpfe_pkg::req_t    req,
  input  logic              full,
  output logic              push,
  output bpfe_pkg::cmd_t    cmd
);

  logic known;

  always_comb begin
    known               = 1'b1;
    cmd.sample_index    = req.sample_index;
    cmd.sample_value    = req.sample_value;
    cmd.query_x         = req.query_x;
    cmd.query_y         = req.query_y;
    cmd.ox              = bpfe_pkg::order_x(req.quantity);
    cmd.oy              = bpfe_pkg::order_y(req.quantity);
    cmd.kind            = bpfe_pkg::CMD_LOAD;
    unique case (req.op)
      bpfe_pkg::OP_LOAD:  cmd.kind = bpfe_pkg::CMD_LOAD;
      bpfe_pkg::OP_BUILD: cmd.kind = bpfe_pkg::CMD_BUILD;
      bpfe_pkg::OP_QUERY: cmd.kind = bpfe_pkg::CMD_QUERY;
      default:            known    = 1'b0;
    endcase
    if (req.quantity == bpfe_pkg::QTY_INTEGRAL) begin
      cmd.qkind = bpfe_pkg::QK_INTEGRAL;
    end else if (req.quantity <= bpfe_pkg::QTY_LAST_DERIV) begin
      cmd.qkind = bpfe_pkg::QK_DERIV;
    end else begin
      cmd.qkind = bpfe_pkg::QK_NONE;
    end
  end

  assign req_ready = !full;
  assign push      = req_valid && !full && known;

endmodule

/* rtl/bpfe_queue.sv */
// Short command queue between intake and execution.
// Depends on bpfe_pkg.
module bpfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bpfe_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bpfe_pkg::cmd_t head
);

  localparam int DEPTH = bpfe_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  bpfe_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/bpfe_qmul.sv */
// Iterative saturating fixed-point multiplier: four 24x24 partial products, then combine.
// Depends on bpfe_pkg.
module bpfe_qmul #(
  parameter int FRACTION_BITS = bpfe_pkg::FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [bpfe_pkg::VAL_BITS-1:0] a,
  input  logic signed [bpfe_pkg::VAL_BITS-1:0] b,
  output logic signed [bpfe_pkg::VAL_BITS-1:0] res,
  output logic                                 sat,
  output logic                                 done
);

  localparam int VB = bpfe_pkg::VAL_BITS;
  localparam int HB = VB / 2;
  localparam int RW = VB + 3;
  localparam logic [2:0] STEP_FINISH = 3'd4;

  logic          busy;
  logic [2:0]    step;
  logic [VB-1:0] ma;
  logic [VB-1:0] mb;
  logic          neg;
  logic [VB-1:0] p2;
  logic [VB:0]   p1;
  logic [VB-1:0] p0;
  logic [HB-1:0] mx;
  logic [HB-1:0] my;
  logic [VB-1:0] prod;
  logic          ovf;
  logic [RW-1:0] r;
  logic [RW-1:0] lim;
  logic signed [VB-1:0] res_next;
  logic          sat_next;

  always_comb begin
    case (step)
      3'd0:    begin mx = ma[VB-1:HB]; my = mb[VB-1:HB]; end
      3'd1:    begin mx = ma[VB-1:HB]; my = mb[HB-1:0];  end
      3'd2:    begin mx = ma[HB-1:0];  my = mb[VB-1:HB]; end
      default: begin mx = ma[HB-1:0];  my = mb[HB-1:0];  end
    endcase
    prod = VB'(mx) * VB'(my);
    ovf  = (p2 >= (VB'(1) << FRACTION_BITS)) || (p1 >= ((VB+1)'(1) << (FRACTION_BITS + HB)));
    r    = (RW'(p2) << (VB - FRACTION_BITS)) + (RW'(p1) << (HB - FRACTION_BITS))
         + RW'(((VB+1)'(p0) + ((VB+1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS);
    lim  = neg ? (RW'(1) << (VB - 1)) : ((RW'(1) << (VB - 1)) - RW'(1));
    if (ovf || (r > lim)) begin
      sat_next = 1'b1;
      res_next = neg ? VB'(bpfe_pkg::VAL_MIN) : VB'(bpfe_pkg::VAL_MAX);
    end else begin
      sat_next = 1'b0;
      res_next = neg ? -VB'(r) : VB'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_FINISH) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= bpfe_pkg::mag48(a);
      mb  <= bpfe_pkg::mag48(b);
      neg <= a[VB-1] != b[VB-1];
    end else if (busy) begin
      case (step)
        3'd0:        p2  <= prod;
        3'd1:        p1  <= (VB+1)'(prod);
        3'd2:        p1  <= p1 + (VB+1)'(prod);
        3'd3:        p0  <= prod;
        default: begin
          res <= res_next;
          sat <= sat_next;
        end
      endcase
    end
  end

endmodule

/* rtl/bpfe_div.sv */
// Rounding divider by a small divisor, four quotient bits per cycle.
// Depends on bpfe_pkg.
module bpfe_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [bpfe_pkg::VAL_BITS-1:0] num,
  input  logic [4:0]                           den,
  output logic signed [bpfe_pkg::VAL_BITS+1:0] quo,
  output logic                                 done
);

  localparam int VB     = bpfe_pkg::VAL_BITS;
  localparam int NB     = VB + 4;
  localparam int RADIX  = 4;
  localparam int CYCLES = NB / RADIX;
  localparam int CNTW   = $clog2(CYCLES + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NB-1:0]   dv;
  logic [4:0]      rem;
  logic [4:0]      dn;
  logic            neg;
  logic [NB-1:0]   dv_next;
  logic [4:0]      rem_next;

  always_comb begin
    dv_next  = dv;
    rem_next = rem;
    for (int s = 0; s < RADIX; s++) begin
      rem_next = {rem_next[3:0], dv_next[NB-1]};
      dv_next  = {dv_next[NB-2:0], 1'b0};
      if (rem_next >= dn) begin
        rem_next   = rem_next - dn;
        dv_next[0] = 1'b1;
      end
    end
  end

  assign quo = neg ? -(VB+2)'(dv) : (VB+2)'(dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNTW'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= NB'(bpfe_pkg::mag48(num)) + NB'(den >> 1);
      rem <= '0;
      dn  <= den;
      neg <= num[VB-1];
    end else if (busy) begin
      dv  <= dv_next;
      rem <= rem_next;
    end
  end

endmodule

/* rtl/bpfe_back.sv */
// Execution sequencer: sample store, coefficient build, query evaluation, result register.
// Depends on bpfe_pkg, bpfe_qmul and bpfe_div.
module bpfe_back #(
  parameter int FRACTION_BITS = bpfe_pkg::FRACTION_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  bpfe_pkg::cmd_t head,
  output logic           pop,
  input  bpfe_pkg::cfg_t cfg,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bpfe_pkg::rsp_t rsp
);

  localparam int VB = bpfe_pkg::VAL_BITS;
  localparam int SB = bpfe_pkg::SAMPLE_BITS;
  localparam int SW = bpfe_pkg::SUM_BITS;
  localparam int AW = SB + 10;
  localparam logic signed [VB-1:0] ONE = VB'(1) << FRACTION_BITS;

  bpfe_pkg::back_state_t state, state_next, ret_state, ret_next;

  logic signed [SB-1:0] grid [16];
  logic signed [VB-1:0] coef [16];
  logic signed [VB-1:0] xp [4];
  logic signed [VB-1:0] yp [4];
  logic [3:0]           row;
  logic [3:0]           k;
  logic signed [AW-1:0] acc;
  logic signed [VB-1:0] val;
  logic [1:0]           cnt_x;
  logic [1:0]           cnt_y;
  logic signed [VB-1:0] base_x;
  logic signed [VB-1:0] base_y;
  logic [1:0]           nx;
  logic [1:0]           ny;
  logic [1:0]           pi;
  logic [1:0]           pj;
  bpfe_pkg::qkind_t     qkind;
  logic [1:0]           ox;
  logic [1:0]           oy;
  logic [1:0]           ti;
  logic [1:0]           tj;
  logic signed [SW-1:0] sum;
  logic                 sat;

  logic                 mul_start;
  logic signed [VB-1:0] mul_a;
  logic signed [VB-1:0] mul_b;
  logic signed [VB-1:0] mul_res;
  logic                 mul_sat;
  logic                 mul_done;
  logic                 div_start;
  logic [4:0]           div_den;
  logic signed [VB+1:0] div_q;
  logic                 div_done;

  logic [AW-1:0]        acc_mag;
  logic signed [AW-1:0] acc_rnd;
  logic [VB:0]          rnd_clamp;
  logic [VB:0]          sum_clamp;
  logic [5:0]           factor;
  logic signed [SW-1:0] fterm;
  logic                 out_free;

  bpfe_qmul #(.FRACTION_BITS(FRACTION_BITS)) u_qmul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .res(mul_res), .sat(mul_sat), .done(mul_done)
  );

  bpfe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(mul_res), .den(div_den),
    .quo(div_q), .done(div_done)
  );

  always_comb begin
    acc_mag   = acc[AW-1] ? AW'(-acc) : AW'(acc);
    acc_rnd   = AW'((acc_mag + AW'(2)) >> 2);
    acc_rnd   = acc[AW-1] ? -acc_rnd : acc_rnd;
    rnd_clamp = bpfe_pkg::clamp_val(SW'(acc_rnd));
    sum_clamp = bpfe_pkg::clamp_val(sum);
    factor    = 6'(bpfe_pkg::fall(ox, ti)) * 6'(bpfe_pkg::fall(oy, tj));
    fterm     = SW'(mul_res) * SW'(signed'({1'b0, factor}));
    div_den   = (5'(ti) + 5'd1) * (5'(tj) + 5'd1);
    out_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpfe_pkg::S_IDLE;
      ret_state <= bpfe_pkg::S_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    pop        = 1'b0;
    mul_start  = 1'b0;
    mul_a      = val;
    mul_b      = VB'(cfg.inverse_width);
    div_start  = 1'b0;
    unique case (state)
      bpfe_pkg::S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.kind)
            bpfe_pkg::CMD_BUILD: state_next = bpfe_pkg::S_BACC;
            bpfe_pkg::CMD_QUERY: begin
              state_next = (head.qkind == bpfe_pkg::QK_NONE) ? bpfe_pkg::S_QFIN
                                                              : bpfe_pkg::S_QPX;
            end
            default:             state_next = bpfe_pkg::S_IDLE;
          endcase
        end
      end
      bpfe_pkg::S_BACC: begin
        if (k == 4'd15) begin
          state_next = bpfe_pkg::S_BRND;
        end
      end
      bpfe_pkg::S_BRND: state_next = bpfe_pkg::S_BSCL;
      bpfe_pkg::S_BSCL: begin
        if (cnt_x != 2'd0 || cnt_y != 2'd0) begin
          mul_start  = 1'b1;
          mul_b      = (cnt_x != 2'd0) ? VB'(cfg.inverse_width) : VB'(cfg.inverse_height);
          ret_next   = bpfe_pkg::S_BGET;
          state_next = bpfe_pkg::S_MULW;
        end else begin
          state_next = (row == 4'd15) ? bpfe_pkg::S_IDLE : bpfe_pkg::S_BACC;
        end
      end
      bpfe_pkg::S_BGET: state_next = bpfe_pkg::S_BSCL;
      bpfe_pkg::S_MULW: begin
        if (mul_done) begin
          state_next = ret_state;
        end
      end
      bpfe_pkg::S_QPX: begin
        if (nx != 2'd0) begin
          mul_start  = 1'b1;
          mul_a      = xp[pi - 2'd1];
          mul_b      = base_x;
          ret_next   = bpfe_pkg::S_QPXG;
          state_next = bpfe_pkg::S_MULW;
        end else begin
          state_next = bpfe_pkg::S_QPY;
        end
      end
      bpfe_pkg::S_QPXG: state_next = bpfe_pkg::S_QPX;
      bpfe_pkg::S_QPY: begin
        if (ny != 2'd0) begin
          mul_start  = 1'b1;
          mul_a      = yp[pj - 2'd1];
          mul_b      = base_y;
          ret_next   = bpfe_pkg::S_QPYG;
          state_next = bpfe_pkg::S_MULW;
        end else begin
          state_next = bpfe_pkg::S_QT1;
        end
      end
      bpfe_pkg::S_QPYG: state_next = bpfe_pkg::S_QPY;
      bpfe_pkg::S_QT1: begin
        mul_start  = 1'b1;
        mul_a      = coef[{ti, tj}];
        mul_b      = xp[ti - ox];
        ret_next   = bpfe_pkg::S_QT2;
        state_next = bpfe_pkg::S_MULW;
      end
      bpfe_pkg::S_QT2: begin
        mul_start  = 1'b1;
        mul_a      = mul_res;
        mul_b      = yp[tj - oy];
        ret_next   = bpfe_pkg::S_QT3;
        state_next = bpfe_pkg::S_MULW;
      end
      bpfe_pkg::S_QT3: begin
        if (qkind == bpfe_pkg::QK_INTEGRAL) begin
          div_start  = 1'b1;
          state_next = bpfe_pkg::S_QDIV;
        end else begin
          state_next = bpfe_pkg::S_QNEXT;
        end
      end
      bpfe_pkg::S_QDIV: begin
        if (div_done) begin
          state_next = bpfe_pkg::S_QNEXT;
        end
      end
      bpfe_pkg::S_QNEXT: begin
        state_next = (tj == 2'd3 && ti == 2'd3) ? bpfe_pkg::S_QFIN : bpfe_pkg::S_QT1;
      end
      bpfe_pkg::S_QFIN: begin
        if (out_free) begin
          state_next = bpfe_pkg::S_IDLE;
        end
      end
      default: state_next = bpfe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < 16; e++) begin
        coef[e] <= '0;
      end
    end else if (state == bpfe_pkg::S_BSCL && cnt_x == 2'd0 && cnt_y == 2'd0) begin
      coef[row] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == bpfe_pkg::S_QFIN && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bpfe_pkg::S_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            bpfe_pkg::CMD_LOAD: grid[head.sample_index] <= head.sample_value;
            bpfe_pkg::CMD_BUILD: begin
              row <= '0;
              k   <= '0;
              acc <= '0;
            end
            default: begin
              sum    <= '0;
              sat    <= 1'b0;
              qkind  <= head.qkind;
              ox     <= head.ox;
              oy     <= head.oy;
              ti     <= head.ox;
              tj     <= head.oy;
              nx     <= 2'd3 - head.ox;
              ny     <= 2'd3 - head.oy;
              pi     <= 2'd1;
              pj     <= 2'd1;
              if (head.qkind == bpfe_pkg::QK_INTEGRAL) begin
                base_x <= VB'(cfg.cell_width);
                base_y <= VB'(cfg.cell_height);
                xp[0]  <= VB'(cfg.cell_width);
                yp[0]  <= VB'(cfg.cell_height);
              end else begin
                base_x <= VB'(head.query_x);
                base_y <= VB'(head.query_y);
                xp[0]  <= ONE;
                yp[0]  <= ONE;
              end
            end
          endcase
        end
      end
      bpfe_pkg::S_BACC: begin
        acc <= acc + AW'(bpfe_pkg::KMAT[row][k]) * AW'(grid[k]);
        k   <= k + 4'd1;
      end
      bpfe_pkg::S_BRND: begin
        val   <= rnd_clamp[VB-1:0];
        cnt_x <= row[3:2];
        cnt_y <= row[1:0];
      end
      bpfe_pkg::S_BSCL: begin
        if (cnt_x != 2'd0) begin
          cnt_x <= cnt_x - 2'd1;
        end else if (cnt_y != 2'd0) begin
          cnt_y <= cnt_y - 2'd1;
        end else begin
          row <= row + 4'd1;
          k   <= '0;
          acc <= '0;
        end
      end
      bpfe_pkg::S_BGET: val <= mul_res;
      bpfe_pkg::S_MULW: begin
        if (mul_done) begin
          sat <= sat | mul_sat;
        end
      end
      bpfe_pkg::S_QPXG: begin
        xp[pi] <= mul_res;
        pi     <= pi + 2'd1;
        nx     <= nx - 2'd1;
      end
      bpfe_pkg::S_QPYG: begin
        yp[pj] <= mul_res;
        pj     <= pj + 2'd1;
        ny     <= ny - 2'd1;
      end
      bpfe_pkg::S_QT3: begin
        if (qkind != bpfe_pkg::QK_INTEGRAL) begin
          sum <= sum + fterm;
        end
      end
      bpfe_pkg::S_QDIV: begin
        if (div_done) begin
          sum <= sum + SW'(div_q);
        end
      end
      bpfe_pkg::S_QNEXT: begin
        if (tj == 2'd3) begin
          tj <= oy;
          ti <= ti + 2'd1;
        end else begin
          tj <= tj + 2'd1;
        end
      end
      bpfe_pkg::S_QFIN: begin
        if (out_free) begin
          rsp.result_value <= sum_clamp[VB-1:0];
          rsp.saturated    <= sat | sum_clamp[VB];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
